// File: src/tra_pkg.sv
// Shared types and constants of the temporal raster aggregator.
package tra_pkg;

    // Fixed sizes of the datapath
    localparam int SAMPLE_BITS = 16;
    localparam int SUM_BITS    = SAMPLE_BITS + 16;
    localparam int MAX_PIXELS  = 4096;
    localparam int POS_BITS    = $clog2(MAX_PIXELS);
    localparam int SIZE_BITS   = POS_BITS + 1;
    localparam int MAX_FRAMES  = 65536;
    localparam int COUNT_BITS  = $clog2(MAX_FRAMES) + 1;
    localparam int REM_BITS    = COUNT_BITS - 1;
    localparam int DIV_STAGES  = SUM_BITS;
    localparam int MODE_BITS   = 2;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 16;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_MODE          = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_NODATA_ENABLE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_NODATA_VALUE  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PIXELS        = 2'd3;

    // Aggregation modes; any other code averages
    localparam logic [MODE_BITS-1:0] MODE_MIN = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_MAX = 2'd1;

    typedef struct packed {
        logic [MODE_BITS-1:0]          mode;
        logic                          nodata_enable;
        logic signed [SAMPLE_BITS-1:0] nodata_value;
        logic [SIZE_BITS-1:0]          pixels_per_frame;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] pixel_value;
        logic                          first_frame;
        logic                          last_frame;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] result_value;
        logic                          result_missing;
        logic                          end_of_frame;
    } out_item_t;

    // One accumulator entry: sticky mark and running value
    typedef struct packed {
        logic                       mark;
        logic signed [SUM_BITS-1:0] value;
    } acc_entry_t;

    // Closed window leaving the accumulator stage
    typedef struct packed {
        logic                       valid;
        logic                       mark;
        logic                       eof;
        logic signed [SUM_BITS-1:0] value;
        logic [COUNT_BITS-1:0]      divisor;
    } acc_item_t;

    // Quotient and side data leaving the divider
    typedef struct packed {
        logic                   valid;
        logic                   neg;
        logic                   mark;
        logic                   eof;
        logic [SAMPLE_BITS-1:0] minmax;
        logic [SUM_BITS-1:0]    quot;
    } div_result_t;

endpackage

// File: src/temporal_raster_aggregator_core.sv
// Top level of the temporal raster aggregator: configuration and pipeline control.
//
// Pixels of successive frames enter in raster order on the s_ channel, one request
// per cycle while s_ready is high. Each updates its own accumulator entry (minimum,
// maximum or saturating sum, plus a sticky no-data mark). Pixels of a frame flagged
// last_frame each give one result request on the m_ channel; other pixels give none.
// From acceptance to m_valid an item passes one read stage, one combine-and-write
// stage, the divider's load register, 32 divider stages (one quotient bit each) and
// the output queue. Throughput is one pixel per cycle while the pipeline is not
// held, set by the single read and single write port of the accumulator memory.
// A two-entry output queue lets input flow on while one result waits; when it is
// full and m_ready is low, the whole pipeline holds and s_ready drops.
// Reset clears position, frame count, valid bits and the configuration registers;
// accumulator contents are undefined until written by a first_frame pixel.
// Configuration registers are written through cfg_wr_en, cfg_index and cfg_wdata; the user
// must write them only while the block is idle, as the block itself does not enforce it.
module temporal_raster_aggregator_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [tra_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [tra_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  tra_pkg::in_item_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output tra_pkg::out_item_t                  m_data
);
    import tra_pkg::*;

    cfg_t        cfg_reg;
    acc_item_t   acc;
    div_result_t res;
    logic        room;
    logic        enable;

    // Advance the pipeline unless the output queue is full and held
    assign enable  = room || m_ready;
    assign s_ready = enable;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode             <= MODE_MIN;
            cfg_reg.nodata_enable    <= 1'b0;
            cfg_reg.nodata_value     <= '0;
            cfg_reg.pixels_per_frame <= SIZE_BITS'(MAX_PIXELS);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MODE:          cfg_reg.mode <= cfg_wdata[MODE_BITS-1:0];
                REG_NODATA_ENABLE: cfg_reg.nodata_enable <= cfg_wdata[0];
                REG_NODATA_VALUE:  cfg_reg.nodata_value <= cfg_wdata[SAMPLE_BITS-1:0];
                REG_PIXELS:        cfg_reg.pixels_per_frame <= cfg_wdata[SIZE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    tra_accum u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .enable  (enable),
        .s_valid (s_valid),
        .s_data  (s_data),
        .cfg     (cfg_reg),
        .acc     (acc)
    );

    tra_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .enable  (enable),
        .acc     (acc),
        .res     (res)
    );

    tra_result u_result (
        .aclk    (aclk),
        .aresetn (aresetn),
        .enable  (enable),
        .res     (res),
        .cfg     (cfg_reg),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: src/tra_accum.sv
// Pixel position, frame count and per-pixel accumulator read-modify-write.
module tra_accum (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              enable,
    input  logic              s_valid,
    input  tra_pkg::in_item_t s_data,
    input  tra_pkg::cfg_t     cfg,
    output tra_pkg::acc_item_t acc
);
    import tra_pkg::*;

    acc_entry_t            mem [MAX_PIXELS];

    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    logic                  s1_valid_reg;
    logic [POS_BITS-1:0]   s1_pos_reg;
    logic signed [SAMPLE_BITS-1:0] s1_px_reg;
    logic                  s1_first_reg;
    logic                  s1_last_reg;
    logic                  s1_missing_reg;
    logic                  s1_eof_reg;
    logic [COUNT_BITS-1:0] s1_div_reg;

    acc_entry_t            rdata_reg;
    logic                  fwd_hit_reg;
    acc_entry_t            fwd_data_reg;

    acc_item_t             acc_reg;

    logic                  accept;
    logic [SIZE_BITS-1:0]  size;
    logic                  eof;
    logic                  missing;
    logic [COUNT_BITS-1:0] divisor;
    acc_entry_t            old_entry;
    acc_entry_t            new_entry;

    assign accept = enable && s_valid;

    // Clip the frame size and find the frame end
    always_comb begin
        if (cfg.pixels_per_frame == '0) begin
            size = SIZE_BITS'(1);
        end else if (cfg.pixels_per_frame > SIZE_BITS'(MAX_PIXELS)) begin
            size = SIZE_BITS'(MAX_PIXELS);
        end else begin
            size = cfg.pixels_per_frame;
        end
        eof      = ({1'b0, pos_reg} + SIZE_BITS'(1)) >= size;
        pos_next = eof ? '0 : pos_reg + POS_BITS'(1);
        missing  = cfg.nodata_enable && (s_data.pixel_value == cfg.nodata_value);
    end

    // Restart or advance the frame count at the first pixel of a frame
    always_comb begin
        count_next = count_reg;
        if (pos_reg == '0) begin
            if (s_data.first_frame) begin
                count_next = COUNT_BITS'(1);
            end else if (count_reg < COUNT_BITS'(MAX_FRAMES)) begin
                count_next = count_reg + COUNT_BITS'(1);
            end
        end
        divisor = (count_next == '0) ? COUNT_BITS'(1) : count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            count_reg <= '0;
        end else if (accept) begin
            pos_reg   <= pos_next;
            count_reg <= count_next;
        end
    end

    // Combine the stored entry with the current pixel
    always_comb begin
        logic signed [SUM_BITS:0] sum;
        old_entry = fwd_hit_reg ? fwd_data_reg : rdata_reg;
        new_entry = old_entry;
        sum = {old_entry.value[SUM_BITS-1], old_entry.value}
            + (SUM_BITS+1)'(s1_px_reg);
        if (s1_first_reg) begin
            new_entry.value = SUM_BITS'(s1_px_reg);
            new_entry.mark  = s1_missing_reg;
        end else begin
            new_entry.mark = old_entry.mark || s1_missing_reg;
            case (cfg.mode)
                MODE_MIN: begin
                    if (SUM_BITS'(s1_px_reg) < old_entry.value) begin
                        new_entry.value = SUM_BITS'(s1_px_reg);
                    end
                end
                MODE_MAX: begin
                    if (SUM_BITS'(s1_px_reg) > old_entry.value) begin
                        new_entry.value = SUM_BITS'(s1_px_reg);
                    end
                end
                default: begin
                    if (sum[SUM_BITS] != sum[SUM_BITS-1]) begin
                        new_entry.value = sum[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                                        : {1'b0, {(SUM_BITS-1){1'b1}}};
                    end else begin
                        new_entry.value = sum[SUM_BITS-1:0];
                    end
                end
            endcase
        end
    end

    // Read at acceptance, write back when the item leaves the combine stage
    always_ff @(posedge aclk) begin
        if (enable && s1_valid_reg) begin
            mem[s1_pos_reg] <= new_entry;
        end
        if (accept) begin
            rdata_reg <= mem[pos_reg];
        end
    end

    // Forward a write that lands on the address read at the same edge
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else if (enable) begin
            fwd_hit_reg <= accept && s1_valid_reg && (s1_pos_reg == pos_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            fwd_data_reg <= new_entry;
        end
    end

    // Combine stage control and payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (enable) begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pos_reg     <= pos_reg;
            s1_px_reg      <= s_data.pixel_value;
            s1_first_reg   <= s_data.first_frame;
            s1_last_reg    <= s_data.last_frame;
            s1_missing_reg <= missing;
            s1_eof_reg     <= eof;
            s1_div_reg     <= divisor;
        end
    end

    // Pass on closed windows only
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg.valid <= 1'b0;
        end else if (enable) begin
            acc_reg.valid <= s1_valid_reg && s1_last_reg;
        end
        if (enable) begin
            acc_reg.mark    <= new_entry.mark;
            acc_reg.eof     <= s1_eof_reg;
            acc_reg.value   <= new_entry.value;
            acc_reg.divisor <= s1_div_reg;
        end
    end

    assign acc = acc_reg;

endmodule

// File: src/tra_divider.sv
// Pipelined restoring divider: one quotient bit per stage.
module tra_divider (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 enable,
    input  tra_pkg::acc_item_t   acc,
    output tra_pkg::div_result_t res
);
    import tra_pkg::*;

    typedef struct packed {
        logic                   neg;
        logic                   mark;
        logic                   eof;
        logic [SAMPLE_BITS-1:0] minmax;
        logic [COUNT_BITS-1:0]  divisor;
        logic [REM_BITS-1:0]    rem;
        logic [SUM_BITS-1:0]    dq;
    } div_stage_t;

    logic       valid_reg [DIV_STAGES+1];
    div_stage_t stage_reg [DIV_STAGES+1];
    div_stage_t load;

    // One shift-and-subtract step
    function automatic div_stage_t div_step(input div_stage_t s);
        div_stage_t            r;
        logic [COUNT_BITS-1:0] trial;
        logic                  ge;
        r     = s;
        trial = {s.rem, s.dq[SUM_BITS-1]};
        ge    = trial >= s.divisor;
        r.rem = ge ? REM_BITS'(trial - s.divisor) : REM_BITS'(trial);
        r.dq  = {s.dq[SUM_BITS-2:0], ge};
        return r;
    endfunction

    // Take the magnitude of the dividend
    always_comb begin
        load.neg     = acc.value[SUM_BITS-1];
        load.mark    = acc.mark;
        load.eof     = acc.eof;
        load.minmax  = acc.value[SAMPLE_BITS-1:0];
        load.divisor = acc.divisor;
        load.rem     = '0;
        load.dq      = acc.value[SUM_BITS-1] ? (~acc.value + SUM_BITS'(1)) : acc.value;
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= DIV_STAGES; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else if (enable) begin
            valid_reg[0] <= acc.valid;
            for (int k = 0; k < DIV_STAGES; k++) begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end
    end

    // Advance stage payload
    always_ff @(posedge aclk) begin
        if (enable) begin
            stage_reg[0] <= load;
            for (int k = 0; k < DIV_STAGES; k++) begin
                stage_reg[k+1] <= div_step(stage_reg[k]);
            end
        end
    end

    assign res.valid  = valid_reg[DIV_STAGES];
    assign res.neg    = stage_reg[DIV_STAGES].neg;
    assign res.mark   = stage_reg[DIV_STAGES].mark;
    assign res.eof    = stage_reg[DIV_STAGES].eof;
    assign res.minmax = stage_reg[DIV_STAGES].minmax;
    assign res.quot   = stage_reg[DIV_STAGES].dq;

endmodule

// File: src/tra_result.sv
// Result formatting and two-entry output queue.
module tra_result (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 enable,
    input  tra_pkg::div_result_t res,
    input  tra_pkg::cfg_t        cfg,
    output logic                 room,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tra_pkg::out_item_t   m_data
);
    import tra_pkg::*;

    out_item_t  queue_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    out_item_t  item;
    logic       push;
    logic       pop;

    localparam logic [SUM_BITS-1:0] POS_LIMIT = SUM_BITS'((1 << (SAMPLE_BITS-1)) - 1);
    localparam logic [SUM_BITS-1:0] NEG_LIMIT = SUM_BITS'(1 << (SAMPLE_BITS-1));

    // Sign, clamp and select the result value
    always_comb begin
        logic signed [SAMPLE_BITS-1:0] avg;
        if (res.neg) begin
            avg = (res.quot >= NEG_LIMIT) ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                          : (~res.quot[SAMPLE_BITS-1:0] + SAMPLE_BITS'(1));
        end else begin
            avg = (res.quot > POS_LIMIT) ? {1'b0, {(SAMPLE_BITS-1){1'b1}}}
                                         : res.quot[SAMPLE_BITS-1:0];
        end
        item.result_missing = res.mark;
        item.end_of_frame   = res.eof;
        if (res.mark) begin
            item.result_value = cfg.nodata_value;
        end else if (cfg.mode == MODE_MIN || cfg.mode == MODE_MAX) begin
            item.result_value = res.minmax;
        end else begin
            item.result_value = avg;
        end
    end

    assign room    = (fill_reg != 2'd2);
    assign push    = enable && res.valid;
    assign pop     = m_valid && m_ready;
    assign m_valid = (fill_reg != 2'd0);
    assign m_data  = queue_reg[rd_ptr_reg];

    // Queue pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

// File: test/tb_temporal_raster_aggregator_core.sv
// Testbench for temporal_raster_aggregator_core: directed and random pixel streams checked live.
module tb_temporal_raster_aggregator_core;
    import tra_pkg::*;

    // Mode codes that the package leaves unnamed
    localparam logic [MODE_BITS-1:0] MODE_MEAN  = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;

    localparam int DRAIN_CYCLES = 48;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 1_000_000;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]    cfg_index = REG_MODE;
    logic [CFG_DATA_BITS-1:0]   cfg_wdata = '0;
    logic                       s_valid   = 1'b0;
    logic                       s_ready;
    in_item_t                   s_data    = '0;
    logic                       m_valid;
    logic                       m_ready   = 1'b0;
    out_item_t                  m_data;

    temporal_raster_aggregator_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Aggregator shadow: accumulators, position, frame count and registers
    longint                 acc_value  [MAX_PIXELS];
    bit                     acc_marked [MAX_PIXELS];
    bit                     acc_seeded [MAX_PIXELS];
    int                     pix_pos    = 0;
    int                     frame_cnt  = 0;
    logic [MODE_BITS-1:0]   cur_mode   = MODE_MIN;
    bit                     cur_nd_en  = 1'b0;
    logic [SAMPLE_BITS-1:0] cur_nd_val = '0;
    logic [SIZE_BITS-1:0]   cur_ppf    = SIZE_BITS'(MAX_PIXELS);

    out_item_t expected_results [$];
    out_item_t head_result;

    int fail_count    = 0;
    int cycle_count   = 0;
    int pixels_sent   = 0;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Abort a run that hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Drive m_ready: random stalls, or a long hold-off when one is requested
    always @(posedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            m_ready     <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Compare every accepted result with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d/%0b/%0b", $time,
                         $signed(m_data.result_value), m_data.result_missing,
                         m_data.end_of_frame);
                fail_count++;
            end else begin
                head_result = expected_results.pop_front();
                check_field("result_value", int'($signed(head_result.result_value)),
                            int'($signed(m_data.result_value)));
                check_field("result_missing", int'(head_result.result_missing),
                            int'(m_data.result_missing));
                check_field("end_of_frame", int'(head_result.end_of_frame),
                            int'(m_data.end_of_frame));
            end
        end
    end

    function automatic longint clamp_signed(longint v, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Effective frame size: zero acts as one, oversize acts as the maximum
    function automatic int frame_len();
        if (cur_ppf == 0) return 1;
        if (cur_ppf > MAX_PIXELS) return MAX_PIXELS;
        return int'(cur_ppf);
    endfunction

    // Update the shadow accumulator for one accepted pixel; queue its result if any
    function automatic void aggregate_pixel(in_item_t req);
        longint    px;
        longint    nd;
        longint    agg;
        longint    divisor;
        int        pos;
        bit        eof;
        bit        miss;
        out_item_t res;
        px  = longint'($signed(req.pixel_value));
        nd  = longint'($signed(cur_nd_val));
        pos = (pix_pos >= MAX_PIXELS) ? 0 : pix_pos;
        eof = (pos + 1 >= frame_len());

        // Count frames at pixel zero only
        if (pos == 0) begin
            if (req.first_frame) frame_cnt = 1;
            else if (frame_cnt < MAX_FRAMES) frame_cnt++;
        end

        miss = cur_nd_en && (px == nd);
        if (req.first_frame) begin
            acc_value[pos]  = px;
            acc_marked[pos] = miss;
            acc_seeded[pos] = 1'b1;
        end else begin
            acc_marked[pos] = acc_marked[pos] || miss;
            case (cur_mode)
                MODE_MIN: begin
                    if (px < acc_value[pos]) acc_value[pos] = px;
                end
                MODE_MAX: begin
                    if (px > acc_value[pos]) acc_value[pos] = px;
                end
                default: begin
                    acc_value[pos] = clamp_signed(acc_value[pos] + px, SUM_BITS);
                end
            endcase
        end
        pix_pos = eof ? 0 : pos + 1;

        if (req.last_frame) begin
            if (acc_marked[pos]) begin
                agg = nd;
            end else if (cur_mode == MODE_MIN || cur_mode == MODE_MAX) begin
                agg = acc_value[pos];
            end else begin
                divisor = (frame_cnt == 0) ? 1 : frame_cnt;
                agg = clamp_signed(acc_value[pos] / divisor, SAMPLE_BITS);
            end
            res.result_value   = agg[SAMPLE_BITS-1:0];
            res.result_missing = acc_marked[pos];
            res.end_of_frame   = eof;
            expected_results.push_back(res);
        end
    endfunction

    // Present one request and hold it until accepted; never read an unseeded entry
    task automatic send_pixel(logic [SAMPLE_BITS-1:0] value, bit first, bit last);
        in_item_t req;
        req.pixel_value = value;
        req.first_frame = first || !acc_seeded[pix_pos];
        req.last_frame  = last;
        // Idle cycle by cycle at the sender's idle rate
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        aggregate_pixel(req);
        pixels_sent++;
    endtask

    // Pause the sender until every expected result is in and the pipeline is empty
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    // Write all four registers while idle and mirror them
    task automatic apply_config(logic [MODE_BITS-1:0] mode_sel, bit nd_en,
                                logic [SAMPLE_BITS-1:0] nd_val, logic [SIZE_BITS-1:0] ppf);
        wait_idle();
        write_reg(REG_MODE, CFG_DATA_BITS'(mode_sel));
        write_reg(REG_NODATA_ENABLE, CFG_DATA_BITS'(nd_en));
        write_reg(REG_NODATA_VALUE, CFG_DATA_BITS'(nd_val));
        write_reg(REG_PIXELS, CFG_DATA_BITS'(ppf));
        cfg_wr_en  <= 1'b0;
        cur_mode   = mode_sel;
        cur_nd_en  = nd_en;
        cur_nd_val = nd_val;
        cur_ppf    = ppf;
    endtask

    // Mix of values near the no-data value, extremes and full-range noise
    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(3))
            0:       return cur_nd_val + SAMPLE_BITS'($urandom_range(2)) - 1'b1;
            1:       return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    task automatic send_frame(bit first, bit last);
        for (int i = 0; i < frame_len(); i++) send_pixel(random_sample(), first, last);
    endtask

    task automatic random_config();
        int                     pick;
        logic [SIZE_BITS-1:0]   ppf;
        logic [SAMPLE_BITS-1:0] nd_val;
        pick = $urandom_range(99);
        if (pick < 70) ppf = SIZE_BITS'($urandom_range(1, 8));
        else if (pick < 95) ppf = SIZE_BITS'($urandom_range(9, 40));
        else ppf = '0;
        if ($urandom_range(1)) nd_val = SAMPLE_BITS'($urandom_range(6)) - 16'd3;
        else nd_val = SAMPLE_BITS'($urandom());
        apply_config(MODE_BITS'($urandom_range(3)), 1'($urandom_range(1)), nd_val, ppf);
    endtask

    // One window of whole frames; now and then broken flags or a mode change
    task automatic run_window();
        int frames;
        bit noisy;
        frames = $urandom_range(1, 4);
        noisy  = ($urandom_range(9) == 0);
        for (int f = 0; f < frames; f++) begin
            if (f > 0 && $urandom_range(9) == 0)
                apply_config(MODE_BITS'($urandom_range(3)), cur_nd_en, cur_nd_val, cur_ppf);
            for (int p = 0; p < frame_len(); p++) begin
                if (noisy)
                    send_pixel(random_sample(), 1'($urandom_range(1)),
                               $urandom_range(2) == 0);
                else
                    send_pixel(random_sample(), f == 0, f == frames - 1);
            end
        end
    endtask

    // Minimum with no-data marking at the lowest sample value
    task automatic test_minimum();
        apply_config(MODE_MIN, 1'b1, 16'h8000, 13'd2);
        send_pixel(16'h7FFF, 1'b1, 1'b0);
        send_pixel(16'hFFFB, 1'b1, 1'b0);
        send_pixel(16'h8000, 1'b0, 1'b1);
        send_pixel(16'd7, 1'b0, 1'b1);
    endtask

    // Maximum seeded from the lowest value, no-data disabled
    task automatic test_maximum();
        apply_config(MODE_MAX, 1'b0, 16'h8000, 13'd2);
        send_pixel(16'h8000, 1'b1, 1'b1);
        send_pixel(16'h7FFF, 1'b1, 1'b1);
        send_pixel(16'h8000, 1'b1, 1'b0);
        send_pixel(16'h8000, 1'b1, 1'b0);
        send_pixel(16'h8000, 1'b0, 1'b1);
        send_pixel(16'd3, 1'b0, 1'b1);
    endtask

    // Mean with truncation toward zero; the spare mode code also averages
    task automatic test_mean();
        apply_config(MODE_MEAN, 1'b1, 16'h7FFF, 13'd1);
        send_pixel(16'd7, 1'b1, 1'b0);
        send_pixel(16'hFFFE, 1'b0, 1'b0);
        send_pixel(16'hFFFE, 1'b0, 1'b1);
        apply_config(MODE_SPARE, 1'b1, 16'h7FFF, 13'd1);
        send_pixel(16'hFFF9, 1'b1, 1'b0);
        send_pixel(16'd0, 1'b0, 1'b1);
        send_pixel(16'h7FFF, 1'b1, 1'b0);
        send_pixel(16'd1, 1'b0, 1'b1);
    endtask

    // Change the mode between frames of one window
    task automatic test_mode_switch();
        apply_config(MODE_MIN, 1'b0, 16'd0, 13'd1);
        send_pixel(16'd10, 1'b1, 1'b0);
        apply_config(MODE_MAX, 1'b0, 16'd0, 13'd1);
        send_pixel(16'd20, 1'b0, 1'b0);
        apply_config(MODE_MEAN, 1'b0, 16'd0, 13'd1);
        send_pixel(16'd30, 1'b0, 1'b1);
    endtask

    // Shrink the frame below the position, then zero and oversize frame sizes
    task automatic test_frame_resize();
        apply_config(MODE_MAX, 1'b0, 16'd0, 13'd8);
        repeat (5) send_pixel(random_sample(), 1'b1, 1'b0);
        apply_config(MODE_MAX, 1'b0, 16'd0, 13'd3);
        send_pixel(random_sample(), 1'b0, 1'b1);
        apply_config(MODE_MAX, 1'b0, 16'd0, 13'd0);
        send_pixel(random_sample(), 1'b1, 1'b1);
        apply_config(MODE_MIN, 1'b0, 16'd0, 13'h1FFF);
        repeat (2) send_pixel(random_sample(), 1'b1, 1'b1);
        apply_config(MODE_MIN, 1'b0, 16'd0, 13'd1);
        send_pixel(random_sample(), 1'b0, 1'b1);
    endtask

    // Hold the receiver off while requests keep coming, so the input stalls
    task automatic test_back_pressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        apply_config(MODE_MEAN, 1'b1, random_sample(), 13'd16);
        hold_requests++;
        repeat (8) send_frame(1'b1, 1'b1);
    endtask

    task automatic test_random(int tx_pct, int rx_pct, int n);
        int target;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        target      = pixels_sent + n;
        while (pixels_sent < target) begin
            random_config();
            run_window();
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn     <= 1'b1;
        tx_idle_pct = 22;
        rx_idle_pct = 51;
        test_minimum();
        test_maximum();
        test_mean();
        test_mode_switch();
        test_frame_resize();
        test_back_pressure();
        test_random(22, 51, 250);
        test_random(51, 22, 250);
        test_random(0, 0, 250);
        wait_idle();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
